[rtl/deadline_sorted_timer_queue_core_assert.svh]
// Assertion macros for the deadline-sorted timer queue core.
// Used by the top level; no other dependencies.
`ifndef DEADLINE_SORTED_TIMER_QUEUE_CORE_ASSERT_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// immediate-cycle implication, disabled in reset
`define DSTQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// next-cycle implication, disabled in reset
`define DSTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define DSTQ_ASSERT(lbl, clk, rstn, prop, msg)
`define DSTQ_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[rtl/dstq_pkg.sv]
// Shared types and constants for the deadline-sorted timer queue.
// No dependencies.
package dstq_pkg;

  localparam int ID_W      = 6;
  localparam int TYPE_W    = 16;
  localparam int CK_W      = 32;
  localparam int DLY_W     = 32;
  localparam int TIME_W    = 64;
  localparam int RES_CAP   = 16;
  localparam int CAP_W     = 5;

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_KILL  = 2'd1,
    CMD_RESET = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_KILL   = 2'd1,
    KIND_RESET  = 2'd2,
    KIND_EXPIRY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_KILL,
    ST_RST,
    ST_SET_CHK,
    ST_SET_CMP,
    ST_TICK_CHK,
    ST_TICK_CMP
  } state_t;

  // order list operation: insert id at pos, or remove entry at pos
  typedef struct packed {
    logic            ins;
    logic            rem;
    logic [ID_W-1:0] pos;
    logic [ID_W-1:0] id;
  } ord_op_t;

endpackage

[rtl/dstq_store.sv]
// Timer record memories indexed by timer id: deadline and type/cookie.
// Depends on dstq_pkg for field widths.
module dstq_store #(
  parameter int MAX_TIMERS = 16,
  parameter int IW = 4
) (
  input  logic                          clk,
  input  logic                          we_dl,
  input  logic                          we_pl,
  input  logic [IW-1:0]                 waddr,
  input  logic [dstq_pkg::TIME_W-1:0]   wdl,
  input  logic [dstq_pkg::TYPE_W-1:0]   wtype,
  input  logic [dstq_pkg::CK_W-1:0]     wck,
  input  logic [IW-1:0]                 raddr,
  output logic [dstq_pkg::TIME_W-1:0]   rdl,
  output logic [dstq_pkg::TYPE_W-1:0]   rtype,
  output logic [dstq_pkg::CK_W-1:0]     rck
);

  logic [dstq_pkg::TIME_W-1:0]                  dl_mem [MAX_TIMERS];
  logic [dstq_pkg::TYPE_W+dstq_pkg::CK_W-1:0]   pl_mem [MAX_TIMERS];

  // write ports
  always_ff @(posedge clk) begin
    if (we_dl) dl_mem[waddr] <= wdl;
    if (we_pl) pl_mem[waddr] <= {wtype, wck};
  end

  // registered read
  always_ff @(posedge clk) begin
    rdl           <= dl_mem[raddr];
    {rtype, rck}  <= pl_mem[raddr];
  end

endmodule

[rtl/dstq_order.sv]
// Queue order list: timer ids by position, with shift insert and remove.
// Depends on dstq_pkg for the operation struct.
module dstq_order #(
  parameter int MAX_TIMERS = 16,
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic                        clk,
  input  dstq_pkg::ord_op_t           op,
  input  logic [CW-1:0]               count,
  input  logic [dstq_pkg::ID_W-1:0]   kill_id,
  input  logic [IW-1:0]               sel_pos,
  output logic [dstq_pkg::ID_W-1:0]   sel_id,
  output logic [dstq_pkg::ID_W-1:0]   head_id,
  output logic [dstq_pkg::ID_W-1:0]   match_pos
);

  logic [IW-1:0] ord_r [MAX_TIMERS];
  logic [IW-1:0] ip;

  assign ip = op.pos[IW-1:0];

  // shift cells on insert or remove
  for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
    always_ff @(posedge clk) begin
      if (op.ins) begin
        if (IW'(g) == ip) ord_r[g] <= op.id[IW-1:0];
        else if (IW'(g) > ip) ord_r[g] <= ord_r[(g > 0) ? g - 1 : 0];
      end else if (op.rem) begin
        if (IW'(g) >= ip) ord_r[g] <= ord_r[(g < MAX_TIMERS - 1) ? g + 1 : g];
      end
    end
  end

  assign sel_id  = dstq_pkg::ID_W'(ord_r[sel_pos]);
  assign head_id = dstq_pkg::ID_W'(ord_r[0]);

  // locate the queued position of a given id
  always_comb begin
    match_pos = '0;
    for (int i = 0; i < MAX_TIMERS; i++) begin
      if (CW'(i) < count && dstq_pkg::ID_W'(ord_r[i]) == kill_id)
        match_pos = dstq_pkg::ID_W'(i);
    end
  end

endmodule

[rtl/deadline_sorted_timer_queue_core.sv]
// Top level of the deadline-sorted timer queue: command sequencer, state.
// Depends on dstq_pkg, dstq_store, dstq_order and the assertion header.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  input    | start / busy        | in_cmd in_timer_id in_timer_type in_cookie
//           |                     | in_delay
//  result   | out_valid (strobe)  | out_kind out_ok out_result_id
//           |                     | out_event_type out_event_cookie out_last
//  config   | cfg_valid/cfg_ready | cfg_data (enabled)
//
// A set compares queued deadlines from the head, one store read per compared
// entry, until one is not earlier or the tail is reached; a refused set
// compares none. A reset with one queued timer retargets it or refuses;
// any other reset removes the timer, if queued, and then runs the set. A
// tick removes expired heads until the 16th expiry, an empty queue or an
// unexpired head ends it. Each word appears in the cycle after its decision;
// busy drops in the cycle that shows the final word. Synchronous active-low
// reset clears the queue count, id map and time. The receiver cannot stall.
`include "deadline_sorted_timer_queue_core_assert.svh"
module deadline_sorted_timer_queue_core #(
  parameter int MAX_TIMERS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_cmd,
  input  logic [dstq_pkg::ID_W-1:0]            in_timer_id,
  input  logic [dstq_pkg::TYPE_W-1:0]          in_timer_type,
  input  logic signed [dstq_pkg::CK_W-1:0]     in_cookie,
  input  logic [dstq_pkg::DLY_W-1:0]           in_delay,
  output logic                                 out_valid,
  output logic [1:0]                           out_kind,
  output logic                                 out_ok,
  output logic [dstq_pkg::ID_W-1:0]            out_result_id,
  output logic [dstq_pkg::TYPE_W-1:0]          out_event_type,
  output logic signed [dstq_pkg::CK_W-1:0]     out_event_cookie,
  output logic                                 out_last,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_data
);

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int CW = $clog2(MAX_TIMERS + 1);

  dstq_pkg::state_t                  state_r, state_nxt;
  logic                              en_r;
  logic [dstq_pkg::TIME_W-1:0]       now_r;
  logic [CW-1:0]                     count_r, count_nxt;
  logic [MAX_TIMERS-1:0]             in_use_r, in_use_nxt;
  dstq_pkg::cmd_t                    cmd_r;
  logic [dstq_pkg::ID_W-1:0]         tid_r;
  logic [dstq_pkg::TYPE_W-1:0]       typ_r;
  logic [dstq_pkg::CK_W-1:0]         ck_r;
  logic [dstq_pkg::TIME_W-1:0]       dl_r;
  logic [CW-1:0]                     p_r, p_nxt;
  logic [dstq_pkg::CAP_W-1:0]        n_r, n_nxt;
  logic                              pend_v_r, pend_v_nxt;
  logic [dstq_pkg::ID_W-1:0]         pend_id_r;
  logic [dstq_pkg::TYPE_W-1:0]       pend_type_r;
  logic [dstq_pkg::CK_W-1:0]         pend_ck_r;
  logic                              pend_ld;

  logic                              out_valid_r, out_valid_nxt;
  dstq_pkg::kind_t                   out_kind_r, out_kind_nxt;
  logic                              out_ok_r, out_ok_nxt;
  logic [dstq_pkg::ID_W-1:0]         out_id_r, out_id_nxt;
  logic [dstq_pkg::TYPE_W-1:0]       out_type_r, out_type_nxt;
  logic [dstq_pkg::CK_W-1:0]         out_ck_r, out_ck_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              accept;
  logic [dstq_pkg::TIME_W:0]         dl_sum;
  logic [dstq_pkg::TIME_W-1:0]       dl_in;
  logic                              free_found;
  logic [dstq_pkg::ID_W-1:0]         free_id;
  logic                              tid_ok, killable;
  logic [IW-1:0]                     tid_idx;
  dstq_pkg::kind_t                   set_kind;

  dstq_pkg::ord_op_t                 op;
  logic [dstq_pkg::ID_W-1:0]         sel_id, head_id, match_pos;
  logic                              st_we_dl, st_we_pl;
  logic [IW-1:0]                     st_waddr, st_raddr;
  logic [dstq_pkg::TIME_W-1:0]       st_rdl;
  logic [dstq_pkg::TYPE_W-1:0]       st_rtype;
  logic [dstq_pkg::CK_W-1:0]         st_rck;

  assign accept    = start && !busy;
  assign busy      = (state_r != dstq_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // saturating deadline from the current time
  assign dl_sum = {1'b0, now_r} + {{(dstq_pkg::TIME_W + 1 - dstq_pkg::DLY_W){1'b0}}, in_delay};
  assign dl_in  = dl_sum[dstq_pkg::TIME_W] ? '1 : dl_sum[dstq_pkg::TIME_W-1:0];

  // lowest free id
  always_comb begin
    free_found = 1'b0;
    free_id    = '0;
    for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_id    = dstq_pkg::ID_W'(i);
      end
    end
  end

  assign tid_ok   = ({1'b0, tid_r} < (dstq_pkg::ID_W + 1)'(MAX_TIMERS));
  assign tid_idx  = tid_r[IW-1:0];
  assign killable = tid_ok && in_use_r[tid_idx];
  assign set_kind = (cmd_r == dstq_pkg::CMD_RESET) ? dstq_pkg::KIND_RESET : dstq_pkg::KIND_SET;

  dstq_store #(.MAX_TIMERS(MAX_TIMERS), .IW(IW)) u_store (
    .clk   (clk),
    .we_dl (st_we_dl),
    .we_pl (st_we_pl),
    .waddr (st_waddr),
    .wdl   (dl_r),
    .wtype (typ_r),
    .wck   (ck_r),
    .raddr (st_raddr),
    .rdl   (st_rdl),
    .rtype (st_rtype),
    .rck   (st_rck)
  );

  dstq_order #(.MAX_TIMERS(MAX_TIMERS), .IW(IW), .CW(CW)) u_order (
    .clk       (clk),
    .op        (op),
    .count     (count_r),
    .kill_id   (tid_r),
    .sel_pos   (p_r[IW-1:0]),
    .sel_id    (sel_id),
    .head_id   (head_id),
    .match_pos (match_pos)
  );

  // next state, queue updates and result word
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    in_use_nxt    = in_use_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    pend_v_nxt    = pend_v_r;
    pend_ld       = 1'b0;
    op            = '0;
    st_we_dl      = 1'b0;
    st_we_pl      = 1'b0;
    st_waddr      = '0;
    st_raddr      = '0;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_ok_nxt    = out_ok_r;
    out_id_nxt    = out_id_r;
    out_type_nxt  = '0;
    out_ck_nxt    = '0;
    out_last_nxt  = 1'b1;
    case (state_r)
      dstq_pkg::ST_IDLE: begin
        if (accept) begin
          p_nxt      = '0;
          n_nxt      = '0;
          pend_v_nxt = 1'b0;
          case (dstq_pkg::cmd_t'(in_cmd))
            dstq_pkg::CMD_SET:   state_nxt = dstq_pkg::ST_SET_CHK;
            dstq_pkg::CMD_KILL:  state_nxt = dstq_pkg::ST_KILL;
            dstq_pkg::CMD_RESET: state_nxt = dstq_pkg::ST_RST;
            default:             state_nxt = dstq_pkg::ST_TICK_CHK;
          endcase
        end
      end
      dstq_pkg::ST_KILL: begin
        if (killable) begin
          op.rem              = 1'b1;
          op.pos              = match_pos;
          count_nxt           = count_r - CW'(1);
          in_use_nxt[tid_idx] = 1'b0;
        end
        out_valid_nxt = 1'b1;
        out_kind_nxt  = dstq_pkg::KIND_KILL;
        out_ok_nxt    = killable;
        out_id_nxt    = tid_r;
        state_nxt     = dstq_pkg::ST_IDLE;
      end
      dstq_pkg::ST_RST: begin
        if (count_r == CW'(1)) begin
          // single timer: retarget in place or refuse
          out_valid_nxt = 1'b1;
          out_kind_nxt  = dstq_pkg::KIND_RESET;
          if (head_id == tid_r) begin
            st_we_dl   = 1'b1;
            st_waddr   = tid_idx;
            out_ok_nxt = 1'b1;
            out_id_nxt = tid_r;
          end else begin
            out_ok_nxt = 1'b0;
            out_id_nxt = '0;
          end
          state_nxt = dstq_pkg::ST_IDLE;
        end else begin
          if (killable) begin
            op.rem              = 1'b1;
            op.pos              = match_pos;
            count_nxt           = count_r - CW'(1);
            in_use_nxt[tid_idx] = 1'b0;
          end
          state_nxt = dstq_pkg::ST_SET_CHK;
        end
      end
      dstq_pkg::ST_SET_CHK: begin
        if (!en_r || !free_found) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = set_kind;
          out_ok_nxt    = 1'b0;
          out_id_nxt    = '0;
          state_nxt     = dstq_pkg::ST_IDLE;
        end else if (p_r == count_r) begin
          op.ins                     = 1'b1;
          op.pos                     = dstq_pkg::ID_W'(p_r);
          op.id                      = free_id;
          st_we_dl                   = 1'b1;
          st_we_pl                   = 1'b1;
          st_waddr                   = free_id[IW-1:0];
          count_nxt                  = count_r + CW'(1);
          in_use_nxt[free_id[IW-1:0]] = 1'b1;
          out_valid_nxt              = 1'b1;
          out_kind_nxt               = set_kind;
          out_ok_nxt                 = 1'b1;
          out_id_nxt                 = free_id;
          state_nxt                  = dstq_pkg::ST_IDLE;
        end else begin
          st_raddr  = sel_id[IW-1:0];
          state_nxt = dstq_pkg::ST_SET_CMP;
        end
      end
      dstq_pkg::ST_SET_CMP: begin
        if (st_rdl < dl_r) begin
          p_nxt     = p_r + CW'(1);
          state_nxt = dstq_pkg::ST_SET_CHK;
        end else begin
          op.ins                     = 1'b1;
          op.pos                     = dstq_pkg::ID_W'(p_r);
          op.id                      = free_id;
          st_we_dl                   = 1'b1;
          st_we_pl                   = 1'b1;
          st_waddr                   = free_id[IW-1:0];
          count_nxt                  = count_r + CW'(1);
          in_use_nxt[free_id[IW-1:0]] = 1'b1;
          out_valid_nxt              = 1'b1;
          out_kind_nxt               = set_kind;
          out_ok_nxt                 = 1'b1;
          out_id_nxt                 = free_id;
          state_nxt                  = dstq_pkg::ST_IDLE;
        end
      end
      dstq_pkg::ST_TICK_CHK: begin
        if (n_r == dstq_pkg::CAP_W'(dstq_pkg::RES_CAP) || count_r == '0) begin
          // flush the held expiry as the final word
          out_valid_nxt = pend_v_r;
          out_kind_nxt  = dstq_pkg::KIND_EXPIRY;
          out_ok_nxt    = 1'b1;
          out_id_nxt    = pend_id_r;
          out_type_nxt  = pend_type_r;
          out_ck_nxt    = pend_ck_r;
          state_nxt     = dstq_pkg::ST_IDLE;
        end else begin
          st_raddr  = head_id[IW-1:0];
          state_nxt = dstq_pkg::ST_TICK_CMP;
        end
      end
      dstq_pkg::ST_TICK_CMP: begin
        out_kind_nxt = dstq_pkg::KIND_EXPIRY;
        out_ok_nxt   = 1'b1;
        out_id_nxt   = pend_id_r;
        out_type_nxt = pend_type_r;
        out_ck_nxt   = pend_ck_r;
        if (st_rdl <= now_r) begin
          // expired head: release held word, hold this one
          out_valid_nxt               = pend_v_r;
          out_last_nxt                = 1'b0;
          pend_v_nxt                  = 1'b1;
          pend_ld                     = 1'b1;
          op.rem                      = 1'b1;
          op.pos                      = '0;
          count_nxt                   = count_r - CW'(1);
          in_use_nxt[head_id[IW-1:0]] = 1'b0;
          n_nxt                       = n_r + dstq_pkg::CAP_W'(1);
          state_nxt                   = dstq_pkg::ST_TICK_CHK;
        end else begin
          out_valid_nxt = pend_v_r;
          state_nxt     = dstq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dstq_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dstq_pkg::ST_IDLE;
      en_r        <= 1'b0;
      now_r       <= '0;
      count_r     <= '0;
      in_use_r    <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      in_use_r    <= in_use_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) en_r <= cfg_data;
      if (accept && dstq_pkg::cmd_t'(in_cmd) == dstq_pkg::CMD_TICK && now_r != '1)
        now_r <= now_r + dstq_pkg::TIME_W'(1);
    end
  end

  // command capture, counters and result payload
  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    n_r <= n_nxt;
    if (accept) begin
      cmd_r <= dstq_pkg::cmd_t'(in_cmd);
      tid_r <= in_timer_id;
      typ_r <= in_timer_type;
      ck_r  <= in_cookie;
      dl_r  <= dl_in;
    end
    if (pend_ld) begin
      pend_id_r   <= head_id;
      pend_type_r <= st_rtype;
      pend_ck_r   <= st_rck;
    end
    if (out_valid_nxt) begin
      out_kind_r <= out_kind_nxt;
      out_ok_r   <= out_ok_nxt;
      out_id_r   <= out_id_nxt;
      out_type_r <= out_type_nxt;
      out_ck_r   <= out_ck_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_ok           = out_ok_r;
  assign out_result_id    = out_id_r;
  assign out_event_type   = out_type_r;
  assign out_event_cookie = out_ck_r;
  assign out_last         = out_last_r;

  `DSTQ_ASSERT(a_count_bound, clk, rst_n, count_r <= CW'(MAX_TIMERS), "queue count over capacity")
  `DSTQ_ASSERT(a_map_count, clk, rst_n, $countones(in_use_r) == int'(count_r), "id map and count disagree")
  `DSTQ_ASSERT(a_ack_last, clk, rst_n, (out_valid_r && out_kind_r != dstq_pkg::KIND_EXPIRY) |-> out_last_r, "ack word without last")
  `DSTQ_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted command left busy low")

endmodule
